### rtl/core/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, constants and helpers of the fixed-point complex ALU.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int DW        = 32;
    localparam int FB        = 16;
    localparam int EXP_W     = 6;
    localparam int EXP_LIMIT = 31;
    localparam int AW        = 2 * DW + 2;
    localparam int CNT_W     = $clog2(EXP_LIMIT + 1);
    localparam int STEP_W    = $clog2(DW);

    localparam logic signed [AW-1:0] DMAX_W = {{(AW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [AW-1:0] DMIN_W = {{(AW-DW+1){1'b1}}, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] ONE_FX = {{(DW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};

    typedef enum logic [2:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CONJ, OP_NEG, OP_POW, OP_EQ
    } op_t;

    typedef enum logic [1:0] {
        ST_OK, ST_DIV_ZERO, ST_OVERFLOW
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_SIMPLE, S_PW_CHK, S_MAC, S_MUL_FIN,
        S_DIV_CHK, S_DIV_RUN, S_DIV_FIN, S_DONE
    } state_t;

    typedef struct packed {
        op_t                   op;
        logic signed [DW-1:0]  a_re;
        logic signed [DW-1:0]  a_im;
        logic signed [DW-1:0]  b_re;
        logic signed [DW-1:0]  b_im;
        logic [CNT_W-1:0]      cnt;
        logic                  recip;
    } req_t;

    typedef struct packed {
        logic signed [DW-1:0] val;
        logic                 ovf;
    } sat_t;

    function automatic logic signed [AW-1:0] sx(input logic signed [DW-1:0] v);
        sx = {{(AW-DW){v[DW-1]}}, v};
    endfunction

    function automatic sat_t sat_fn(input logic signed [AW-1:0] v);
        sat_t s;
        if (v > DMAX_W)
        begin
            s.val = DMAX_W[DW-1:0];
            s.ovf = 1'b1;
        end
        else if (v < DMIN_W)
        begin
            s.val = DMIN_W[DW-1:0];
            s.ovf = 1'b1;
        end
        else
        begin
            s.val = v[DW-1:0];
            s.ovf = 1'b0;
        end
        return s;
    endfunction

endpackage

### rtl/core/complex_arith_unit_core.sv
// ----------------------------------------------------------------------------
// complex_arith_unit_core
// Q16.16 complex ALU: add, sub, mul, div, conj, neg, integer power, equality.
// ----------------------------------------------------------------------------
// One request is processed at a time by the back end while the front queue
// (two deep) keeps accepting until it is full. A multiply runs four products
// through the single shared 32x32 multiplier; a divide uses the one-bit-per-
// cycle divider over 32 quotient bits; power runs one complex multiply per
// step of the square-and-multiply loop (at most 9 for an exponent of 31),
// followed by a complex divide for a negative exponent.
// The finished result sits in an output register, so the next request starts
// while the previous one is still waiting to be taken.
module complex_arith_unit_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [2:0]                       opcode,
    input  logic signed [cau_pkg::DW-1:0]    a_re,
    input  logic signed [cau_pkg::DW-1:0]    a_im,
    input  logic signed [cau_pkg::DW-1:0]    b_re,
    input  logic signed [cau_pkg::DW-1:0]    b_im,
    input  logic signed [cau_pkg::EXP_W-1:0] exponent,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [cau_pkg::DW-1:0]    res_re,
    output logic signed [cau_pkg::DW-1:0]    res_im,
    output logic                             is_equal,
    output logic [1:0]                       status
);
    import cau_pkg::*;

    logic q_valid;
    logic q_pop;
    req_t q_req;

    cau_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .opcode   (opcode),
        .a_re     (a_re),
        .a_im     (a_im),
        .b_re     (b_re),
        .b_im     (b_im),
        .exponent (exponent),
        .q_valid  (q_valid),
        .q_req    (q_req),
        .q_pop    (q_pop)
    );

    cau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_req     (q_req),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_re    (res_re),
        .res_im    (res_im),
        .is_equal  (is_equal),
        .status    (status)
    );

endmodule

### rtl/core/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front
// Accepts requests, folds the exponent into a clamped count, and queues them.
// ----------------------------------------------------------------------------
module cau_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [2:0]                  opcode,
    input  logic signed [cau_pkg::DW-1:0]    a_re,
    input  logic signed [cau_pkg::DW-1:0]    a_im,
    input  logic signed [cau_pkg::DW-1:0]    b_re,
    input  logic signed [cau_pkg::DW-1:0]    b_im,
    input  logic signed [cau_pkg::EXP_W-1:0] exponent,
    output logic                        q_valid,
    output cau_pkg::req_t               q_req,
    input  logic                        q_pop
);
    import cau_pkg::*;

    req_t             fifo_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push;
    logic [EXP_W:0]   exp_abs;
    req_t             new_req;

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_req    = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        exp_abs = exponent[EXP_W-1] ? -{exponent[EXP_W-1], exponent}
                                    : {exponent[EXP_W-1], exponent};
        new_req.op    = op_t'(opcode);
        new_req.a_re  = a_re;
        new_req.a_im  = a_im;
        new_req.b_re  = b_re;
        new_req.b_im  = b_im;
        new_req.recip = exponent[EXP_W-1];
        if (exp_abs > (EXP_W+1)'(EXP_LIMIT))
            new_req.cnt = CNT_W'(EXP_LIMIT);
        else
            new_req.cnt = exp_abs[CNT_W-1:0];
    end

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = (q_pop && q_valid) ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop && q_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= new_req;
    end

endmodule

### rtl/core/cau_back.sv
// ----------------------------------------------------------------------------
// cau_back
// Sequencer with one shared multiplier and a two-lane radix-2 divider; output register.
// ----------------------------------------------------------------------------
module cau_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  cau_pkg::req_t                 q_req,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [cau_pkg::DW-1:0] res_re,
    output logic signed [cau_pkg::DW-1:0] res_im,
    output logic                          is_equal,
    output logic [1:0]                    status
);
    import cau_pkg::*;

    state_t state_reg, state_next;

    op_t                  op_reg, op_next;
    logic signed [DW-1:0] rr_reg, rr_next, ri_reg, ri_next;
    logic signed [DW-1:0] zr_reg, zr_next, zi_reg, zi_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 recip_reg, recip_next;
    logic                 sq_reg, sq_next;
    logic                 dmode_reg, dmode_next;
    logic                 ovf_reg, ovf_next;
    logic                 dz_reg, dz_next;
    logic                 eq_reg, eq_next;
    logic [2:0]           iss_reg, iss_next;
    logic signed [2*DW-1:0] p_reg, p_next;
    logic signed [AW-1:0] acc0_reg, acc0_next, acc1_reg, acc1_next, acc2_reg, acc2_next;
    logic [2*DW-1:0]      rem0_reg, rem0_next, rem1_reg, rem1_next;
    logic [DW-1:0]        qs0_reg, qs0_next, qs1_reg, qs1_next;
    logic                 big0_reg, big0_next, big1_reg, big1_next;
    logic                 neg0_reg, neg0_next, neg1_reg, neg1_next;
    logic [STEP_W-1:0]    step_reg, step_next;

    logic                 ov_reg, ov_next;
    logic signed [DW-1:0] ore_reg, ore_next, oim_reg, oim_next;
    logic                 oeq_reg, oeq_next;
    logic [1:0]           ost_reg, ost_next;

    logic                 out_free;
    logic [2:0]           last_iss;
    logic signed [DW-1:0] xr, xi, mx, my;
    logic signed [AW-1:0] pe;
    logic [AW-1:0]        abs0, abs1, den_w;
    logic [2*DW:0]        t0, t1;
    logic [DW:0]          m0, m1;
    logic signed [AW-1:0] v0, v1;
    sat_t                 s0, s1;

    assign out_free  = !ov_reg || !out_stall;
    assign out_valid = ov_reg;
    assign res_re    = ore_reg;
    assign res_im    = oim_reg;
    assign is_equal  = oeq_reg;
    assign status    = ost_reg;
    assign last_iss  = dmode_reg ? 3'd5 : 3'd3;
    assign xr        = sq_reg ? zr_reg : rr_reg;
    assign xi        = sq_reg ? zi_reg : ri_reg;
    assign pe        = {{(AW-2*DW){p_reg[2*DW-1]}}, p_reg};
    assign den_w     = {2'b00, acc2_reg[2*DW-1:0]};

    always_comb
    begin
        unique case (iss_reg)
            3'd0:    begin mx = xr;     my = zr_reg; end
            3'd1:    begin mx = xi;     my = zi_reg; end
            3'd2:    begin mx = xi;     my = zr_reg; end
            3'd3:    begin mx = xr;     my = zi_reg; end
            3'd4:    begin mx = zr_reg; my = zr_reg; end
            default: begin mx = zi_reg; my = zi_reg; end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_req.op) inside
                        OP_MUL, OP_DIV: state_next = S_MAC;
                        OP_POW:         state_next = S_PW_CHK;
                        default:        state_next = S_SIMPLE;
                    endcase
                end
            end
            S_SIMPLE:  state_next = S_DONE;
            S_PW_CHK:
            begin
                if (cnt_reg != '0 || recip_reg)
                    state_next = S_MAC;
                else
                    state_next = S_DONE;
            end
            S_MAC:
            begin
                if (iss_reg == last_iss + 3'd1)
                    state_next = dmode_reg ? S_DIV_CHK : S_MUL_FIN;
            end
            S_MUL_FIN: state_next = (op_reg == OP_POW) ? S_PW_CHK : S_DONE;
            S_DIV_CHK: state_next = (acc2_reg == '0) ? S_DONE : S_DIV_RUN;
            S_DIV_RUN:
            begin
                if (step_reg == STEP_W'(DW - 1))
                    state_next = S_DIV_FIN;
            end
            S_DIV_FIN: state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        q_pop = (state_reg == S_IDLE) && q_valid;
    end

    // datapath
    always_comb
    begin
        op_next = op_reg;  rr_next = rr_reg;  ri_next = ri_reg;
        zr_next = zr_reg;  zi_next = zi_reg;  cnt_next = cnt_reg;
        recip_next = recip_reg;  sq_next = sq_reg;  dmode_next = dmode_reg;
        ovf_next = ovf_reg;  dz_next = dz_reg;  eq_next = eq_reg;
        iss_next = iss_reg;  p_next = p_reg;
        acc0_next = acc0_reg;  acc1_next = acc1_reg;  acc2_next = acc2_reg;
        rem0_next = rem0_reg;  rem1_next = rem1_reg;
        qs0_next = qs0_reg;  qs1_next = qs1_reg;
        big0_next = big0_reg;  big1_next = big1_reg;
        neg0_next = neg0_reg;  neg1_next = neg1_reg;
        step_next = step_reg;
        ore_next = ore_reg;  oim_next = oim_reg;  oeq_next = oeq_reg;  ost_next = ost_reg;
        ov_next = out_stall ? ov_reg : 1'b0;

        abs0 = acc0_reg[AW-1] ? AW'(-acc0_reg) : AW'(acc0_reg);
        abs1 = acc1_reg[AW-1] ? AW'(-acc1_reg) : AW'(acc1_reg);
        t0 = {rem0_reg, qs0_reg[DW-1]};
        t1 = {rem1_reg, qs1_reg[DW-1]};
        m0 = big0_reg ? {1'b1, {DW{1'b0}}} : {1'b0, qs0_reg};
        m1 = big1_reg ? {1'b1, {DW{1'b0}}} : {1'b0, qs1_reg};
        v0 = neg0_reg ? -AW'(m0) : AW'(m0);
        v1 = neg1_reg ? -AW'(m1) : AW'(m1);
        s0 = sat_fn(v0);
        s1 = sat_fn(v1);

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    op_next = q_req.op;
                    rr_next = q_req.a_re;  ri_next = q_req.a_im;
                    zr_next = q_req.b_re;  zi_next = q_req.b_im;
                    cnt_next = q_req.cnt;  recip_next = q_req.recip;
                    ovf_next = 1'b0;  dz_next = 1'b0;  eq_next = 1'b0;
                    sq_next = 1'b0;  dmode_next = (q_req.op == OP_DIV);
                    iss_next = '0;
                    acc0_next = '0;  acc1_next = '0;  acc2_next = '0;
                    if (q_req.op == OP_POW)
                    begin
                        rr_next = ONE_FX;  ri_next = '0;
                        zr_next = q_req.a_re;  zi_next = q_req.a_im;
                    end
                end
            end
            S_SIMPLE:
            begin
                case (op_reg)
                    OP_ADD:
                    begin
                        s0 = sat_fn(sx(rr_reg) + sx(zr_reg));
                        s1 = sat_fn(sx(ri_reg) + sx(zi_reg));
                    end
                    OP_SUB:
                    begin
                        s0 = sat_fn(sx(rr_reg) - sx(zr_reg));
                        s1 = sat_fn(sx(ri_reg) - sx(zi_reg));
                    end
                    OP_CONJ:
                    begin
                        s0 = sat_fn(sx(rr_reg));
                        s1 = sat_fn(-sx(ri_reg));
                    end
                    OP_NEG:
                    begin
                        s0 = sat_fn(-sx(rr_reg));
                        s1 = sat_fn(-sx(ri_reg));
                    end
                    default:
                    begin
                        s0 = sat_fn('0);
                        s1 = sat_fn('0);
                        eq_next = (rr_reg == zr_reg) && (ri_reg == zi_reg);
                    end
                endcase
                rr_next = s0.val;  ri_next = s1.val;
                ovf_next = s0.ovf || s1.ovf;
            end
            S_PW_CHK:
            begin
                iss_next = '0;
                acc0_next = '0;  acc1_next = '0;  acc2_next = '0;
                if (cnt_reg == '0)
                begin
                    if (recip_reg)
                    begin
                        zr_next = rr_reg;  zi_next = ri_reg;
                        rr_next = ONE_FX;  ri_next = '0;
                        sq_next = 1'b0;  dmode_next = 1'b1;
                    end
                end
                else if (cnt_reg[0])
                begin
                    sq_next = 1'b0;  dmode_next = 1'b0;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    sq_next = 1'b1;  dmode_next = 1'b0;
                    cnt_next = cnt_reg >> 1;
                end
            end
            S_MAC:
            begin
                if (iss_reg <= last_iss)
                    p_next = mx * my;
                iss_next = iss_reg + 3'd1;
                case (iss_reg)
                    3'd1: acc0_next = acc0_reg + pe;
                    3'd2: acc0_next = dmode_reg ? acc0_reg + pe : acc0_reg - pe;
                    3'd3: acc1_next = acc1_reg + pe;
                    3'd4: acc1_next = dmode_reg ? acc1_reg - pe : acc1_reg + pe;
                    3'd5: acc2_next = acc2_reg + pe;
                    3'd6: acc2_next = acc2_reg + pe;
                    default: ;
                endcase
            end
            S_MUL_FIN:
            begin
                s0 = sat_fn(acc0_reg >>> FB);
                s1 = sat_fn(acc1_reg >>> FB);
                ovf_next = ovf_reg || s0.ovf || s1.ovf;
                if (sq_reg)
                begin
                    zr_next = s0.val;  zi_next = s1.val;
                end
                else
                begin
                    rr_next = s0.val;  ri_next = s1.val;
                end
            end
            S_DIV_CHK:
            begin
                if (acc2_reg == '0)
                    dz_next = 1'b1;
                rem0_next = (2*DW)'(abs0 >> (DW - FB));
                rem1_next = (2*DW)'(abs1 >> (DW - FB));
                big0_next = (abs0 >> (DW - FB)) >= den_w;
                big1_next = (abs1 >> (DW - FB)) >= den_w;
                qs0_next = {abs0[DW-FB-1:0], {FB{1'b0}}};
                qs1_next = {abs1[DW-FB-1:0], {FB{1'b0}}};
                neg0_next = acc0_reg[AW-1];
                neg1_next = acc1_reg[AW-1];
                step_next = '0;
            end
            S_DIV_RUN:
            begin
                step_next = step_reg + STEP_W'(1);
                if (t0 >= den_w[2*DW:0])
                begin
                    rem0_next = (2*DW)'(t0 - den_w[2*DW:0]);
                    qs0_next = {qs0_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rem0_next = t0[2*DW-1:0];
                    qs0_next = {qs0_reg[DW-2:0], 1'b0};
                end
                if (t1 >= den_w[2*DW:0])
                begin
                    rem1_next = (2*DW)'(t1 - den_w[2*DW:0]);
                    qs1_next = {qs1_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rem1_next = t1[2*DW-1:0];
                    qs1_next = {qs1_reg[DW-2:0], 1'b0};
                end
            end
            S_DIV_FIN:
            begin
                rr_next = s0.val;  ri_next = s1.val;
                ovf_next = ovf_reg || s0.ovf || s1.ovf;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    oeq_next = eq_reg;
                    if (dz_reg)
                    begin
                        ore_next = '0;  oim_next = '0;  ost_next = ST_DIV_ZERO;
                    end
                    else
                    begin
                        ore_next = (op_reg == OP_EQ) ? '0 : rr_reg;
                        oim_next = (op_reg == OP_EQ) ? '0 : ri_reg;
                        ost_next = ovf_reg ? ST_OVERFLOW : ST_OK;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;  rr_reg <= rr_next;  ri_reg <= ri_next;
        zr_reg <= zr_next;  zi_reg <= zi_next;  cnt_reg <= cnt_next;
        recip_reg <= recip_next;  sq_reg <= sq_next;  dmode_reg <= dmode_next;
        ovf_reg <= ovf_next;  dz_reg <= dz_next;  eq_reg <= eq_next;
        iss_reg <= iss_next;  p_reg <= p_next;
        acc0_reg <= acc0_next;  acc1_reg <= acc1_next;  acc2_reg <= acc2_next;
        rem0_reg <= rem0_next;  rem1_reg <= rem1_next;
        qs0_reg <= qs0_next;  qs1_reg <= qs1_next;
        big0_reg <= big0_next;  big1_reg <= big1_next;
        neg0_reg <= neg0_next;  neg1_reg <= neg1_next;
        step_reg <= step_next;
        ore_reg <= ore_next;  oim_reg <= oim_next;
        oeq_reg <= oeq_next;  ost_reg <= ost_next;
    end

endmodule
